// ===== rtl/core/ckb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared constants, register indexes and controller/datapath types for the
// color-keyed sprite blitter.
// ----------------------------------------------------------------------------
package ckb_pkg;

	// size limits
	localparam int MAX_SCREEN_SIDE     = 2048;
	localparam int MAX_SPRITE_SIDE     = 2048;
	localparam int MAX_BYTES_PER_PIXEL = 4;

	// field widths
	localparam int SIDE_W  = 12;
	localparam int BPP_W   = 3;
	localparam int COLOR_W = 32;
	localparam int POS_W   = 16;
	localparam int ADDR_W  = 24;
	localparam int BYTE_W  = 8;

	// derived widths
	localparam int CRD_W  = $clog2(MAX_SCREEN_SIDE);
	localparam int CNT_W  = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;
	localparam int PRD_W  = 2 * CRD_W + 1;
	localparam int KSEL_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

	// register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd7;

	// effective (clamped) configuration
	typedef struct packed {
		logic [SIDE_W-1:0]  scr_w;
		logic [SIDE_W-1:0]  scr_h;
		logic [BPP_W-1:0]   bpp;
		logic [COLOR_W-1:0] key;
		logic [POS_W-1:0]   org_x;
		logic [POS_W-1:0]   org_y;
		logic [SIDE_W-1:0]  spr_w;
		logic [SIDE_W-1:0]  spr_h;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic next;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
	} sts_t;

endpackage

// ===== rtl/core/color_key_sprite_blit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_key_sprite_blit
// Color-keyed sprite blit with screen clipping: turns a row-major stream of
// sprite pixels into frame buffer byte writes.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_*       in   tdata[31:0] pixel_color
//  m_*       out  tdata[23:0] byte_address, [31:24] byte_value; tlast last_byte
//  cfg_*     in   cfg_index register number, cfg_data value (low bits used)
//
//  A keyed or clipped pixel only steps the sprite position and writes no
//  bytes. A visible pixel goes through accept, multiply by the screen width,
//  scale by the byte count, then one byte beat per cycle while m_tready is high.
//  Output stalls hold the current byte beat; no new pixel is taken until the
//  last byte of the current one is out. Reset clears the counters and loads
//  the register defaults.
// ----------------------------------------------------------------------------
module color_key_sprite_blit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // pixel_color
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // byte_address, byte_value
	output logic                           m_tlast,   // last_byte
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ckb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import ckb_pkg::*;

	cfg_t               cfg;
	cmd_t               cmd;
	sts_t               sts;
	logic [ADDR_W-1:0]  byte_address;
	logic [BYTE_W-1:0]  byte_value;

	// configuration registers
	ckb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	ckb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// address and byte datapath
	ckb_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_color  (s_tdata),
		.byte_address (byte_address),
		.byte_value   (byte_value)
	);

	assign m_tdata = {byte_value, byte_address};
	assign m_tlast = sts.last;

endmodule

// ===== rtl/core/ckb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_regs
// Configuration register file with clamping of the sizes to their legal range.
// ----------------------------------------------------------------------------
module ckb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ckb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output ckb_pkg::cfg_t                  cfg
);
	import ckb_pkg::*;

	logic [SIDE_W-1:0]  scr_w_q, scr_h_q, spr_w_q, spr_h_q;
	logic [BPP_W-1:0]   bpp_q;
	logic [COLOR_W-1:0] key_q;
	logic [POS_W-1:0]   org_x_q, org_y_q;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SIDE_W'(1024);
			scr_h_q <= SIDE_W'(768);
			bpp_q   <= BPP_W'(1);
			key_q   <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			spr_w_q <= SIDE_W'(1);
			spr_h_q <= SIDE_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  scr_w_q <= cfg_data[SIDE_W-1:0];
				REG_SCREEN_HEIGHT: scr_h_q <= cfg_data[SIDE_W-1:0];
				REG_PIXEL_BYTES:   bpp_q   <= cfg_data[BPP_W-1:0];
				REG_KEY_COLOR:     key_q   <= cfg_data[COLOR_W-1:0];
				REG_ORIGIN_X:      org_x_q <= cfg_data[POS_W-1:0];
				REG_ORIGIN_Y:      org_y_q <= cfg_data[POS_W-1:0];
				REG_SPRITE_WIDTH:  spr_w_q <= cfg_data[SIDE_W-1:0];
				REG_SPRITE_HEIGHT: spr_h_q <= cfg_data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped view
	always_comb begin
		cfg.scr_w = (32'(scr_w_q) > 32'(MAX_SCREEN_SIDE)) ? SIDE_W'(MAX_SCREEN_SIDE) : scr_w_q;
		cfg.scr_h = (32'(scr_h_q) > 32'(MAX_SCREEN_SIDE)) ? SIDE_W'(MAX_SCREEN_SIDE) : scr_h_q;
		if (bpp_q == '0)
			cfg.bpp = BPP_W'(1);
		else if (32'(bpp_q) > 32'(MAX_BYTES_PER_PIXEL))
			cfg.bpp = BPP_W'(MAX_BYTES_PER_PIXEL);
		else
			cfg.bpp = bpp_q;
		cfg.key   = key_q;
		cfg.org_x = org_x_q;
		cfg.org_y = org_y_q;
		if (spr_w_q == '0)
			cfg.spr_w = SIDE_W'(1);
		else if (32'(spr_w_q) > 32'(MAX_SPRITE_SIDE))
			cfg.spr_w = SIDE_W'(MAX_SPRITE_SIDE);
		else
			cfg.spr_w = spr_w_q;
		if (spr_h_q == '0)
			cfg.spr_h = SIDE_W'(1);
		else if (32'(spr_h_q) > 32'(MAX_SPRITE_SIDE))
			cfg.spr_h = SIDE_W'(MAX_SPRITE_SIDE);
		else
			cfg.spr_h = spr_h_q;
	end

endmodule

// ===== rtl/core/ckb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_dpath
// Sprite position counters, clip and key test, address arithmetic and byte
// selection for the blitter.
// ----------------------------------------------------------------------------
module ckb_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ckb_pkg::cfg_t                cfg,
	input  ckb_pkg::cmd_t                cmd,
	output ckb_pkg::sts_t                sts,
	input  logic [ckb_pkg::COLOR_W-1:0]  pixel_color,
	output logic [ckb_pkg::ADDR_W-1:0]   byte_address,
	output logic [ckb_pkg::BYTE_W-1:0]   byte_value
);
	import ckb_pkg::*;

	logic [CNT_W-1:0]   col_q, row_q;
	logic [CNT_W:0]     col_inc, row_inc;
	logic [POS_W-1:0]   x_pos, y_pos;
	logic [CRD_W-1:0]   x_q, y_q;
	logic [COLOR_W-1:0] color_q;
	logic [PRD_W-1:0]   prod_q;
	logic [PRD_W:0]     pix;
	logic [PRD_W+2:0]   scaled;
	logic [ADDR_W-1:0]  addr_q;
	logic [KSEL_W-1:0]  k_q;

	// destination of the incoming pixel
	assign x_pos = cfg.org_x + POS_W'(col_q);
	assign y_pos = cfg.org_y + POS_W'(row_q);
	assign sts.hit = (pixel_color != cfg.key)
		&& (x_pos < POS_W'(cfg.scr_w))
		&& (y_pos < POS_W'(cfg.scr_h));

	assign col_inc = (CNT_W+1)'(col_q) + 1'b1;
	assign row_inc = (CNT_W+1)'(row_q) + 1'b1;

	// sprite position counters, advance on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (32'(col_inc) >= 32'(cfg.spr_w)) begin
				col_q <= '0;
				if (32'(row_inc) >= 32'(cfg.spr_h))
					row_q <= '0;
				else
					row_q <= row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// byte index within the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.load) begin
			k_q <= '0;
		end else if (cmd.next) begin
			k_q <= k_q + 1'b1;
		end
	end

	// pixel payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= pixel_color;
			x_q     <= x_pos[CRD_W-1:0];
			y_q     <= y_pos[CRD_W-1:0];
		end
	end

	// row offset y * screen_width
	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= PRD_W'(y_q) * PRD_W'(cfg.scr_w[CRD_W:0]);
	end

	// pixel index scaled by bytes per pixel
	assign pix = (PRD_W+1)'(prod_q) + (PRD_W+1)'(x_q);
	always_comb begin
		case (cfg.bpp)
			3'd2:    scaled = {1'b0, pix, 1'b0};
			3'd3:    scaled = (PRD_W+3)'({pix, 1'b0}) + (PRD_W+3)'(pix);
			3'd4:    scaled = {pix, 2'b00};
			default: scaled = (PRD_W+3)'(pix);
		endcase
	end

	// byte address, steps by one per beat
	always_ff @(posedge clk) begin
		if (cmd.scale)
			addr_q <= ADDR_W'(scaled);
		else if (cmd.next)
			addr_q <= addr_q + 1'b1;
	end

	assign byte_address = addr_q;
	assign byte_value   = BYTE_W'(color_q >> {k_q, 3'b000});
	assign sts.last     = (BPP_W'(k_q) + 1'b1) == cfg.bpp;

endmodule

// ===== rtl/core/ckb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_ctrl
// Sequencer: accepts a pixel, steps the address arithmetic and issues one
// byte beat per cycle of the output handshake.
// ----------------------------------------------------------------------------
module ckb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ckb_pkg::sts_t  sts,
	output ckb_pkg::cmd_t  cmd
);
	import ckb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.hit)
						state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) begin
					cmd.next = 1'b1;
					if (sts.last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== verif/ckb_blit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_blit_checker
// Watches the pixel, byte write and register channels of the sprite blitter,
// predicts the frame buffer byte writes of every accepted pixel and compares
// each accepted byte beat with the oldest write still due.
// ----------------------------------------------------------------------------
module ckb_blit_checker
	import ckb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [31:0]           s_tdata,    // pixel_color
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [31:0]           m_tdata,    // byte_address, byte_value
	input  logic                  m_tlast,    // last_byte
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	output int                    fail_count,
	output int                    writes_due
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] value;
		logic              last;
	} byte_write_t;

	// byte writes predicted but not yet seen on the output
	byte_write_t pending_writes[$];

	// shadow copy of the registers and the sprite position
	logic [SIDE_W-1:0]  scr_w, scr_h, spr_w, spr_h;
	logic [BPP_W-1:0]   bpp;
	logic [COLOR_W-1:0] key;
	logic [POS_W-1:0]   org_x, org_y;
	int unsigned        col, row;

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// queue the byte writes of one sprite pixel and step the sprite position
	task automatic blit_pixel(input logic [COLOR_W-1:0] color);
		int unsigned w, h, sw, sh, nbytes, x, y;
		longint unsigned base;
		byte_write_t bw;
		w      = clamp(spr_w, 1, MAX_SPRITE_SIDE);
		h      = clamp(spr_h, 1, MAX_SPRITE_SIDE);
		sw     = clamp(scr_w, 0, MAX_SCREEN_SIDE);
		sh     = clamp(scr_h, 0, MAX_SCREEN_SIDE);
		nbytes = clamp(bpp, 1, MAX_BYTES_PER_PIXEL);
		x      = (org_x + col) % 65536;
		y      = (org_y + row) % 65536;
		// position advances for keyed and clipped pixels too
		if (col + 1 >= w) begin
			col = 0;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
		if (color == key || x >= sw || y >= sh)
			return;
		base = (longint'(y) * sw + x) * nbytes;
		for (int k = 0; k < nbytes; k++) begin
			bw.addr  = ADDR_W'(base + k);
			bw.value = BYTE_W'(color >> (8 * k));
			bw.last  = (k == nbytes - 1);
			pending_writes.push_back(bw);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_write_t due;
		if (!arst_n) begin
			scr_w = 12'd1024;
			scr_h = 12'd768;
			bpp   = 3'd1;
			key   = '0;
			org_x = '0;
			org_y = '0;
			spr_w = 12'd1;
			spr_h = 12'd1;
			col   = 0;
			row   = 0;
			pending_writes.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w = cfg_data[SIDE_W-1:0];
					REG_SCREEN_HEIGHT: scr_h = cfg_data[SIDE_W-1:0];
					REG_PIXEL_BYTES:   bpp   = cfg_data[BPP_W-1:0];
					REG_KEY_COLOR:     key   = cfg_data[COLOR_W-1:0];
					REG_ORIGIN_X:      org_x = cfg_data[POS_W-1:0];
					REG_ORIGIN_Y:      org_y = cfg_data[POS_W-1:0];
					REG_SPRITE_WIDTH:  spr_w = cfg_data[SIDE_W-1:0];
					REG_SPRITE_HEIGHT: spr_h = cfg_data[SIDE_W-1:0];
					default: ;
				endcase
			end
			// pixel beat
			if (s_tvalid && s_tready)
				blit_pixel(s_tdata);
			// byte write beat against the oldest one due
			if (m_tvalid && m_tready) begin
				if (pending_writes.size() == 0) begin
					$error("byte write with none due: byte_address %06h byte_value %02h",
						m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+BYTE_W-1:ADDR_W]);
					fail_count++;
				end else begin
					due = pending_writes.pop_front();
					if (m_tdata[ADDR_W-1:0] !== due.addr) begin
						$error("byte_address: expected %06h, actual %06h",
							due.addr, m_tdata[ADDR_W-1:0]);
						fail_count++;
					end
					if (m_tdata[ADDR_W+BYTE_W-1:ADDR_W] !== due.value) begin
						$error("byte_value: expected %02h, actual %02h",
							due.value, m_tdata[ADDR_W+BYTE_W-1:ADDR_W]);
						fail_count++;
					end
					if (m_tlast !== due.last) begin
						$error("last_byte: expected %0b, actual %0b", due.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		writes_due = pending_writes.size();
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sprite blitter with a directed set of corner pixels and then
// random sprites under random register settings, with random gaps on the
// pixel side and random stalls on the byte write side. Checking is done by
// ckb_blit_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import ckb_pkg::*;

	localparam int RANDOM_PIXELS = 440;
	localparam int STALL_LIMIT   = 2000;
	// settle time in drain() once no byte write is due
	localparam int SETTLE_CYCLES = 8;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;     // pixel_color
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;            // byte_address, byte_value
	logic                 m_tlast;            // last_byte
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [31:0]          cfg_data  = '0;
	int                   fail_count;
	int                   writes_due;

	int                   idle_pct  = 28;
	logic [31:0]          key_now   = '0;
	int                   quiet_cycles = 0;

	color_key_sprite_blit uut (.*);
	ckb_blit_checker u_checker (.*);

	always #2 clk = ~clk;

	// random back-pressure on the byte write side
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= idle_pct);

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL color_key_sprite_blit");
			$finish;
		end
	end

	// register write; bits above the register width carry noise
	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		case (idx)
			REG_PIXEL_BYTES:            mask = 32'h0000_0007;
			REG_KEY_COLOR:              mask = 32'hFFFF_FFFF;
			REG_ORIGIN_X, REG_ORIGIN_Y: mask = 32'h0000_FFFF;
			default:                    mask = 32'h0000_0FFF;
		endcase
		if (idx == REG_KEY_COLOR)
			key_now = value;
		cfg_index <= idx;
		cfg_data  <= (value & mask) | ($urandom & ~mask);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one pixel beat; valid stays high unless a gap follows
	task automatic send_pixel(input logic [31:0] color);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		s_tdata  <= color;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every byte write is out and the block has settled
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (writes_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly small sizes, sometimes zero or oversized
	function automatic logic [31:0] pick_side();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 12);
		else if (r < 80)
			return 0;
		else if (r < 90)
			return $urandom_range(MAX_SCREEN_SIDE, 4095);
		else
			return $urandom_range(0, 4095);
	endfunction

	// near the screen corner, near the far edge, wrapping, or anywhere
	function automatic logic [31:0] pick_origin();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 15);
		else if (r < 75)
			return $urandom_range(MAX_SCREEN_SIDE - 8, MAX_SCREEN_SIDE - 1);
		else if (r < 90)
			return 65536 - $urandom_range(1, 12);
		else
			return $urandom_range(0, 65535);
	endfunction

	initial begin
		int pixels_sent;
		pixels_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: keyed black, then visible pixels at the origin
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0001);
		drain();

		// oversized screen, clamped byte count, zero sprite size, far corner
		set_reg(REG_SCREEN_WIDTH, 4095);
		set_reg(REG_SCREEN_HEIGHT, 4095);
		set_reg(REG_PIXEL_BYTES, 7);
		set_reg(REG_KEY_COLOR, 32'hFFFF_FFFF);
		set_reg(REG_ORIGIN_X, MAX_SCREEN_SIDE - 1);
		set_reg(REG_ORIGIN_Y, MAX_SCREEN_SIDE - 1);
		set_reg(REG_SPRITE_WIDTH, 0);
		set_reg(REG_SPRITE_HEIGHT, 0);
		send_pixel(32'hA5C3_0F81);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		drain();

		// sprite wrapping around x = 0, zero byte count, one full sprite and more
		set_reg(REG_SCREEN_WIDTH, MAX_SCREEN_SIDE);
		set_reg(REG_PIXEL_BYTES, 0);
		set_reg(REG_ORIGIN_X, 65535);
		set_reg(REG_ORIGIN_Y, 0);
		set_reg(REG_SPRITE_WIDTH, 3);
		set_reg(REG_SPRITE_HEIGHT, 2);
		repeat (7) send_pixel($urandom);
		drain();

		// sprite shrunk while the column counter is past the new width
		set_reg(REG_SPRITE_WIDTH, 1);
		set_reg(REG_PIXEL_BYTES, 3);
		set_reg(REG_ORIGIN_X, 0);
		repeat (2) send_pixel($urandom);
		drain();

		// zero screen sizes clip everything
		set_reg(REG_SCREEN_WIDTH, 0);
		repeat (2) send_pixel($urandom);
		drain();
		set_reg(REG_SCREEN_WIDTH, 1);
		set_reg(REG_SCREEN_HEIGHT, 0);
		send_pixel($urandom);
		drain();

		// oversized sprite on a one-row screen
		set_reg(REG_SCREEN_HEIGHT, 1);
		set_reg(REG_SCREEN_WIDTH, MAX_SCREEN_SIDE);
		set_reg(REG_SPRITE_WIDTH, 4095);
		set_reg(REG_SPRITE_HEIGHT, 4095);
		set_reg(REG_PIXEL_BYTES, 2);
		set_reg(REG_ORIGIN_X, 65535);
		repeat (3) send_pixel($urandom);
		drain();

		// random sprites under random settings, one stretch without idling
		while (pixels_sent < RANDOM_PIXELS) begin
			idle_pct = (pixels_sent >= 160 && pixels_sent < 280) ? 0 : 28;
			if ($urandom_range(0, 1)) set_reg(REG_SCREEN_WIDTH, pick_side());
			if ($urandom_range(0, 1)) set_reg(REG_SCREEN_HEIGHT, pick_side());
			if ($urandom_range(0, 1)) set_reg(REG_PIXEL_BYTES, $urandom_range(0, 7));
			if ($urandom_range(0, 1))
				set_reg(REG_KEY_COLOR, $urandom_range(0, 1) ? $urandom :
					($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000));
			if ($urandom_range(0, 1)) set_reg(REG_ORIGIN_X, pick_origin());
			if ($urandom_range(0, 1)) set_reg(REG_ORIGIN_Y, pick_origin());
			if ($urandom_range(0, 1)) set_reg(REG_SPRITE_WIDTH, pick_side());
			if ($urandom_range(0, 1)) set_reg(REG_SPRITE_HEIGHT, pick_side());
			repeat ($urandom_range(1, 30)) begin
				send_pixel(($urandom_range(0, 99) < 25) ? key_now : $urandom);
				pixels_sent++;
			end
			drain();
		end

		if (fail_count == 0 && writes_due == 0) begin
			$display("PASS color_key_sprite_blit");
		end else begin
			if (writes_due != 0)
				$error("byte writes still due at the end: %0d", writes_due);
			$display("FAIL color_key_sprite_blit");
		end
		$finish;
	end

endmodule
